// ----- hw/rtl/k_transaction_max_profit_top_macros.svh -----
// Assertion macros for the file that carries checks.
`ifndef K_TRANSACTION_MAX_PROFIT_TOP_MACROS_SVH
`define K_TRANSACTION_MAX_PROFIT_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define KTMP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define KTMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`else

`define KTMP_ASSERT_SAME(label, clk, rst, ante, cons)
`define KTMP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/ktmp_pkg.sv -----
package ktmp_pkg;

  localparam int MAX_TRANSACTIONS = 16;
  localparam int PRICE_BITS       = 16;

  localparam int PRICE_FIELD_BITS = 16;
  localparam int PROFIT_BITS      = 31;
  localparam int CFG_BITS         = 5;
  localparam int VAL_BITS         = 32;

  typedef logic signed [VAL_BITS-1:0] val_t;

  localparam val_t VAL_MIN = {1'b1, {(VAL_BITS-1){1'b0}}};
  localparam val_t VAL_MAX = {1'b0, {(VAL_BITS-1){1'b1}}};

  localparam logic [CFG_BITS-1:0] K_RESET = CFG_BITS'(1);

  typedef struct packed {
    logic [PRICE_FIELD_BITS-1:0] price;
    logic                        last_price;
  } in_word_t;

  typedef struct packed {
    logic [PROFIT_BITS-1:0] best_profit;
    logic                   profit_saturated;
  } out_word_t;

  // Per-cycle control broadcast along the chain.
  typedef struct packed {
    logic step;
    logic clear;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/ktmp_cell.sv -----
module ktmp_cell
  import ktmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctl_t             ctl,
  input  logic [PRICE_BITS-1:0] price,
  input  val_t                  left_flat,
  output val_t                  flat,
  output val_t                  flat_next,
  output logic                  sat
);

  val_t                hold;
  val_t                hold_next;
  logic [VAL_BITS:0]   sell_wide;
  logic [VAL_BITS:0]   buy_wide;
  val_t                sell;
  val_t                buy;
  logic                sell_ovf;
  logic                buy_ovf;

  always_comb begin
    sell_wide = {hold[VAL_BITS-1], hold} + {{(VAL_BITS+1-PRICE_BITS){1'b0}}, price};
    buy_wide  = {left_flat[VAL_BITS-1], left_flat}
              - {{(VAL_BITS+1-PRICE_BITS){1'b0}}, price};

    // The wide result left the 32-bit range when its two top bits differ.
    sell_ovf = sell_wide[VAL_BITS] ^ sell_wide[VAL_BITS-1];
    buy_ovf  = buy_wide[VAL_BITS] ^ buy_wide[VAL_BITS-1];

    if (sell_ovf) begin
      sell = sell_wide[VAL_BITS] ? VAL_MIN : VAL_MAX;
    end else begin
      sell = sell_wide[VAL_BITS-1:0];
    end
    if (buy_ovf) begin
      buy = buy_wide[VAL_BITS] ? VAL_MIN : VAL_MAX;
    end else begin
      buy = buy_wide[VAL_BITS-1:0];
    end

    flat_next = (sell > flat) ? sell : flat;
    hold_next = (buy > hold) ? buy : hold;
    sat       = sell_ovf | buy_ovf;
  end

  always_ff @(posedge clk) begin
    if (rst || (ctl.step && ctl.clear)) begin
      hold <= VAL_MIN;
      flat <= '0;
    end else if (ctl.step) begin
      hold <= hold_next;
      flat <= flat_next;
    end
  end

endmodule

// ----- hw/rtl/k_transaction_max_profit_top.sv -----
// Channel  Direction  Payload       Handshake
// in       input      in_word_t     in_valid / in_ready
// out      output     out_word_t    out_valid / out_ready
// cfg      input      5-bit k       cfg_valid / cfg_ready
//
// One price word is taken per cycle and its result is registered at the same
// edge, so it is offered from the next cycle on. Every cell of the chain
// updates at that edge; the longest path is one add, one compare and the k
// selection. A stalled output holds in_ready low until the word is taken.
// Reset is synchronous; k returns to 1.
`include "k_transaction_max_profit_top_macros.svh"

module k_transaction_max_profit_top
  import ktmp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_word_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_word_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_BITS-1:0] cfg_data
);

  logic [CFG_BITS-1:0]         k_reg;
  logic                        sat_seen;
  logic                        sat_any;
  logic                        flats_zero;
  val_t                        best;
  cell_ctl_t                   ctl;
  logic [PRICE_BITS-1:0]       price;
  val_t                        cell_flat      [MAX_TRANSACTIONS];
  val_t                        cell_flat_next [MAX_TRANSACTIONS];
  val_t                        cell_left      [MAX_TRANSACTIONS];
  logic [MAX_TRANSACTIONS-1:0] cell_sat;

  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign ctl.step  = in_valid && in_ready;
  assign ctl.clear = in_data.last_price;
  assign price     = in_data.price[PRICE_BITS-1:0];

  genvar g;
  generate
    for (g = 0; g < MAX_TRANSACTIONS; g++) begin : g_cell
      // The first count buys from a flat value of zero.
      if (g == 0) begin : g_head
        assign cell_left[g] = '0;
      end else begin : g_link
        assign cell_left[g] = cell_flat[g-1];
      end

      ktmp_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .price     (price),
        .left_flat (cell_left[g]),
        .flat      (cell_flat[g]),
        .flat_next (cell_flat_next[g]),
        .sat       (cell_sat[g])
      );
    end
  endgenerate

  assign sat_any = |cell_sat;

  // A k above the chain length reads the last cell; a k of zero reads nothing.
  always_comb begin
    best = '0;
    for (int j = 0; j < MAX_TRANSACTIONS; j++) begin
      if (int'(k_reg) == j + 1 ||
          (j == MAX_TRANSACTIONS - 1 && int'(k_reg) > MAX_TRANSACTIONS)) begin
        best = cell_flat_next[j];
      end
    end
  end

  always_comb begin
    flats_zero = 1'b1;
    for (int j = 0; j < MAX_TRANSACTIONS; j++) begin
      if (cell_flat[j] != '0) begin
        flats_zero = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg     <= K_RESET;
      sat_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        k_reg <= cfg_data;
      end
      if (ctl.step) begin
        out_valid                 <= 1'b1;
        out_data.best_profit      <= best[VAL_BITS-1] ? '0 : best[PROFIT_BITS-1:0];
        out_data.profit_saturated <= sat_seen | sat_any;
        sat_seen                  <= ctl.clear ? 1'b0 : (sat_seen | sat_any);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `KTMP_ASSERT_NEXT(a_accept_gives_result, clk, rst, ctl.step, out_valid)
  `KTMP_ASSERT_NEXT(a_last_clears_flat, clk, rst, ctl.step && ctl.clear, flats_zero)
  `KTMP_ASSERT_NEXT(a_last_clears_sat, clk, rst, ctl.step && ctl.clear, !sat_seen)
  `KTMP_ASSERT_SAME(a_stall_blocks_input, clk, rst, out_valid && !out_ready, !in_ready)

endmodule

// ----- sim/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ktmp_pkg::*;

  localparam int TOTAL_ITEMS  = 1050;
  localparam int DRAIN_CYCLES = 3;
  localparam int TAIL_CYCLES  = 10;
  localparam int LIMIT_NS     = 1000000;

  typedef enum logic {ROW_PRICE, ROW_K} row_kind_e;

  typedef enum logic [1:0] {SHAPE_UNIFORM, SHAPE_EXTREME, SHAPE_WALK, SHAPE_LOW} price_shape_e;

  typedef struct {
    row_kind_e             kind;
    logic [15:0]           price;
    logic                  last;
    logic [CFG_BITS-1:0]   k;
    bit                    typed;
    logic [PROFIT_BITS-1:0] profit;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data;

  // Own copy of the trading state, updated as each price word is accepted.
  val_t                hold_val [MAX_TRANSACTIONS];
  val_t                flat_val [MAX_TRANSACTIONS];
  logic                sat_seen;
  logic [CFG_BITS-1:0] k_reg;

  out_word_t profit_queue[$];
  stim_row_t directed_rows[$];
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        send_quiet = 0;
  int        recv_quiet = 0;

  k_transaction_max_profit_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void clear_series();
    for (int j = 0; j < MAX_TRANSACTIONS; j++) begin
      hold_val[j] = VAL_MIN;
      flat_val[j] = '0;
    end
    sat_seen = 1'b0;
  endfunction

  function automatic val_t clamp_val(longint v);
    if (v > longint'(VAL_MAX)) begin
      sat_seen = 1'b1;
      return VAL_MAX;
    end
    if (v < longint'(VAL_MIN)) begin
      sat_seen = 1'b1;
      return VAL_MIN;
    end
    return val_t'(v);
  endfunction

  // Every transaction count moves at once from the values before this price.
  function automatic out_word_t price_profit(in_word_t w);
    val_t      prev_flat [MAX_TRANSACTIONS];
    longint    p;
    longint    base;
    val_t      sell;
    val_t      buy;
    val_t      best;
    int        kk;
    out_word_t r;
    p = longint'(w.price[PRICE_BITS-1:0]);
    prev_flat = flat_val;
    for (int j = 0; j < MAX_TRANSACTIONS; j++) begin
      base = (j == 0) ? 64'sd0 : longint'(prev_flat[j-1]);
      sell = clamp_val(longint'(hold_val[j]) + p);
      buy  = clamp_val(base - p);
      if (sell > flat_val[j]) flat_val[j] = sell;
      if (buy > hold_val[j]) hold_val[j] = buy;
    end
    kk = (k_reg > MAX_TRANSACTIONS) ? MAX_TRANSACTIONS : int'(k_reg);
    best = '0;
    if (kk > 0) best = flat_val[kk-1];
    if (best < 0) best = '0;
    r.best_profit = best[PROFIT_BITS-1:0];
    r.profit_saturated = sat_seen;
    if (w.last_price) clear_series();
    return r;
  endfunction

  // Mostly short waits, now and then a long one, and quiet stretches with none.
  function automatic int pick_gap(ref int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(10, 60);
      return 0;
    end
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 19);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_k();
    case ($urandom_range(0, 7))
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'd31;
      default: return CFG_BITS'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic push_price(in_word_t w, bit typed, out_word_t typed_word);
    int        gap;
    out_word_t predicted;
    gap = pick_gap(send_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = price_profit(w);
    profit_queue = {profit_queue, (typed ? typed_word : predicted)};
    items_sent++;
  endtask

  // k is only changed once every outstanding word has come back.
  task automatic write_k(logic [CFG_BITS-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (profit_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    k_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : watch_out
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (profit_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected word, profit %0d", out_data.best_profit));
      end else begin
        want = profit_queue.pop_front();
        if (out_data.best_profit !== want.best_profit)
          report_mismatch($sformatf("best_profit %0d, wanted %0d",
                                    out_data.best_profit, want.best_profit));
        if (out_data.profit_saturated !== want.profit_saturated)
          report_mismatch($sformatf("profit_saturated %0b, wanted %0b",
                                    out_data.profit_saturated, want.profit_saturated));
      end
    end
  end

  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = pick_gap(recv_quiet);
      repeat (gap) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : limit
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

  initial begin : driver
    stim_row_t    row;
    in_word_t     w;
    out_word_t    t;
    int           len;
    int           level;
    price_shape_e shape;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    clear_series();
    k_reg = K_RESET;

    // Extremes, a zero k, a k beyond the chain, changes of k within a series
    // and a series of a single price.
    directed_rows = '{
      '{ROW_PRICE, 16'd0,     1'b0, 5'd0,  1'b1, 31'd0},
      '{ROW_PRICE, 16'd65535, 1'b1, 5'd0,  1'b1, 31'd65535},
      '{ROW_K,     16'd0,     1'b0, 5'd0,  1'b0, 31'd0},
      '{ROW_PRICE, 16'd0,     1'b0, 5'd0,  1'b1, 31'd0},
      '{ROW_PRICE, 16'd65535, 1'b1, 5'd0,  1'b1, 31'd0},
      '{ROW_K,     16'd0,     1'b0, 5'd16, 1'b0, 31'd0},
      '{ROW_PRICE, 16'd0,     1'b0, 5'd0,  1'b0, 31'd0},
      '{ROW_PRICE, 16'd65535, 1'b0, 5'd0,  1'b0, 31'd0},
      '{ROW_PRICE, 16'd0,     1'b0, 5'd0,  1'b0, 31'd0},
      '{ROW_PRICE, 16'd65535, 1'b0, 5'd0,  1'b0, 31'd0},
      '{ROW_PRICE, 16'd0,     1'b0, 5'd0,  1'b0, 31'd0},
      '{ROW_PRICE, 16'd65535, 1'b1, 5'd0,  1'b0, 31'd0},
      '{ROW_K,     16'd0,     1'b0, 5'd31, 1'b0, 31'd0},
      '{ROW_PRICE, 16'd65535, 1'b0, 5'd0,  1'b1, 31'd0},
      '{ROW_PRICE, 16'd1,     1'b0, 5'd0,  1'b0, 31'd0},
      '{ROW_PRICE, 16'd40000, 1'b0, 5'd0,  1'b0, 31'd0},
      '{ROW_K,     16'd0,     1'b0, 5'd2,  1'b0, 31'd0},
      '{ROW_PRICE, 16'd3,     1'b0, 5'd0,  1'b0, 31'd0},
      '{ROW_PRICE, 16'd50000, 1'b0, 5'd0,  1'b0, 31'd0},
      '{ROW_K,     16'd0,     1'b0, 5'd1,  1'b0, 31'd0},
      '{ROW_PRICE, 16'd65535, 1'b1, 5'd0,  1'b0, 31'd0},
      '{ROW_PRICE, 16'd12345, 1'b1, 5'd0,  1'b1, 31'd0},
      '{ROW_K,     16'd0,     1'b0, 5'd17, 1'b0, 31'd0},
      '{ROW_PRICE, 16'd0,     1'b0, 5'd0,  1'b0, 31'd0},
      '{ROW_PRICE, 16'd65535, 1'b1, 5'd0,  1'b0, 31'd0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_K) begin
        write_k(row.k);
      end else begin
        w.price = row.price;
        w.last_price = row.last;
        t.best_profit = row.profit;
        t.profit_saturated = 1'b0;
        push_price(w, row.typed, t);
      end
    end

    // Whole series of random shape and length, k changed now and then between
    // series and occasionally within one.
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 2) == 0) write_k(pick_k());
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      shape = price_shape_e'($urandom_range(0, 3));
      level = $urandom_range(0, 65535);
      for (int n = 0; n < len; n++) begin
        if (n > 0 && $urandom_range(0, 39) == 0) write_k(pick_k());
        case (shape)
          SHAPE_UNIFORM: level = $urandom_range(0, 65535);
          SHAPE_EXTREME: level = $urandom_range(0, 1) ? 65535 : 0;
          SHAPE_WALK: begin
            level = level + int'($urandom_range(0, 400)) - 200;
            if (level < 0) level = 0;
            if (level > 65535) level = 65535;
          end
          default: level = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 15);
        endcase
        w.price = level[15:0];
        w.last_price = (n == len - 1);
        push_price(w, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (profit_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- k_transaction_max_profit_top.f -----
+incdir+hw/rtl
hw/rtl/ktmp_pkg.sv
hw/rtl/ktmp_cell.sv
hw/rtl/k_transaction_max_profit_top.sv
sim/tb.sv
